### src/dbhp_pkg.sv
// Shared types and constants for the distance band haptic pulser.
// No dependencies; every module of the block imports this package.
package dbhp_pkg;

	// Number of range channels, each with one motor.
	localparam int CHANNELS = 3;
	// Drive fields on the result port.
	localparam int OUT_DRIVES = 3;

	localparam int DIST_W = 16;
	localparam int TIME_W = 32;
	localparam int REG_W = 16;
	localparam int IDX_W = 3;
	localparam int CHAN_W = 2;

	// Item kinds.
	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_TICK   = 2'd1,
		ACT_BUTTON = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT = 3'd0;
	localparam logic [IDX_W-1:0] REG_BAND_ONE   = 3'd1;
	localparam logic [IDX_W-1:0] REG_BAND_TWO   = 3'd2;
	localparam logic [IDX_W-1:0] REG_MAX_RANGE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_FAST       = 3'd4;
	localparam logic [IDX_W-1:0] REG_MID        = 3'd5;
	localparam logic [IDX_W-1:0] REG_SLOW       = 3'd6;
	localparam logic [IDX_W-1:0] REG_LOCKOUT    = 3'd7;

	// Configuration register file.
	typedef struct packed {
		logic [REG_W-1:0] near_limit_mm;
		logic [REG_W-1:0] band_one_top_mm;
		logic [REG_W-1:0] band_two_top_mm;
		logic [REG_W-1:0] max_range_mm;
		logic [REG_W-1:0] fast_period_ms;
		logic [REG_W-1:0] mid_period_ms;
		logic [REG_W-1:0] slow_period_ms;
		logic [REG_W-1:0] button_lockout_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		near_limit_mm:     16'd200,
		band_one_top_mm:   16'd500,
		band_two_top_mm:   16'd1000,
		max_range_mm:      16'd2000,
		fast_period_ms:    16'd50,
		mid_period_ms:     16'd100,
		slow_period_ms:    16'd250,
		button_lockout_ms: 16'd200
	};

	// Per-item control from the enable/time unit to the channels.
	typedef struct packed {
		logic              sample_ok;
		logic              clear;
		logic              enabled;
		logic [TIME_W-1:0] now;
	} ctl_t;

endpackage

### src/dbhp_ctrl.sv
// Millisecond counter, button lockout and motor enable of the pulser.
// Depends on dbhp_pkg for the action codes and the control struct.
module dbhp_ctrl import dbhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [1:0]        action,
	input  logic              button_low,
	input  logic [REG_W-1:0]  lockout_ms,
	output ctl_t              ctl
);

	logic [TIME_W-1:0] ms_q, ms_d;
	logic [TIME_W-1:0] press_q, press_d;
	logic              en_q, en_d;
	logic [TIME_W-1:0] since_press;

	assign since_press = ms_q - press_q;

	// Apply the action of the item in stage one to the time and enable state.
	always_comb begin
		ms_d = ms_q;
		press_d = press_q;
		en_d = en_q;
		case (action_t'(action))
			ACT_TICK: begin
				ms_d = ms_q + 32'd1;
			end
			ACT_BUTTON: begin
				if (button_low && (since_press > {16'd0, lockout_ms})) begin
					en_d = ~en_q;
					press_d = ms_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.sample_ok = (action_t'(action) == ACT_SAMPLE) && en_q;
	assign ctl.clear = ~en_d;
	assign ctl.enabled = en_d;
	assign ctl.now = ms_d;

	// State updates once per processed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
			press_q <= '0;
			en_q <= 1'b1;
		end else if (adv) begin
			ms_q <= ms_d;
			press_q <= press_d;
			en_q <= en_d;
		end
	end

endmodule

### src/dbhp_chan.sv
// One motor channel: band decode, blink period and flip timing.
// Depends on dbhp_pkg for the register struct and the control struct.
module dbhp_chan import dbhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              hit,
	input  logic [DIST_W-1:0] distance_mm,
	input  cfg_t              cfg,
	input  ctl_t              ctl,
	output logic              drive_next
);

	logic [REG_W-1:0]  per_q, per_a;
	logic [TIME_W-1:0] last_q;
	logic              tog_q, tog_d;
	logic              drv_q, drv_a;
	logic [TIME_W-1:0] elapsed;
	logic              flip;

	// Sample decode, then forced silence while the motors are disabled.
	always_comb begin
		per_a = per_q;
		drv_a = drv_q;
		if (hit) begin
			if (distance_mm == '0 || distance_mm > cfg.max_range_mm) begin
				per_a = '0;
				drv_a = 1'b0;
			end else if (distance_mm < cfg.near_limit_mm) begin
				per_a = '0;
				drv_a = 1'b1;
			end else if (distance_mm <= cfg.band_one_top_mm) begin
				per_a = cfg.fast_period_ms;
			end else if (distance_mm <= cfg.band_two_top_mm) begin
				per_a = cfg.mid_period_ms;
			end else begin
				per_a = cfg.slow_period_ms;
			end
		end
		if (ctl.clear) begin
			per_a = '0;
			drv_a = 1'b0;
		end
	end

	// Flip check against the wrapping elapsed time.
	assign elapsed = ctl.now - last_q;
	assign flip = (per_a != '0) && (elapsed >= {16'd0, per_a});
	assign tog_d = tog_q ^ flip;
	assign drive_next = flip ? tog_d : drv_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_q <= '0;
			last_q <= '0;
			tog_q <= 1'b0;
			drv_q <= 1'b0;
		end else if (adv) begin
			per_q <= per_a;
			tog_q <= tog_d;
			drv_q <= drive_next;
			if (flip) begin
				last_q <= ctl.now;
			end
		end
	end

endmodule

### src/distance_band_haptic_pulser.sv
// Top level of the distance band haptic pulser: ports, registers, stages.
// Depends on dbhp_pkg, dbhp_ctrl and dbhp_chan.
//
// Each accepted transaction (a distance sample, a millisecond tick or a
// button event) yields exactly one result carrying the three motor drives
// and the enable state after that item. The block takes one transaction per
// clock while the result side keeps up: an item is registered in stage one,
// processed by one pass of compare and subtract logic that updates the
// channel and timing state, and its result is registered as stage one advances.
// An output stall holds the item in stage one, which then keeps the next
// item out. Configuration writes take effect at once and should only be made
// while no transaction is in flight.
module distance_band_haptic_pulser import dbhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration write port
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	// Input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic [CHAN_W-1:0] channel,
	input  logic [DIST_W-1:0] distance_mm,
	input  logic              button_low,
	// Result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic              drive_forward,
	output logic              drive_left,
	output logic              drive_right,
	output logic              motors_enabled
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [CHAN_W-1:0] channel_s1;
	logic [DIST_W-1:0] distance_s1;
	logic              button_s1;
	logic              out_valid_q;
	logic              adv;
	ctl_t              ctl;
	logic [CHANNELS-1:0]   hit;
	logic [CHANNELS-1:0]   drv_next;
	logic [OUT_DRIVES-1:0] drv_pad;
	logic [OUT_DRIVES-1:0] drv_q;
	logic                  en_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR_LIMIT: cfg_q.near_limit_mm <= cfg_data;
				REG_BAND_ONE:   cfg_q.band_one_top_mm <= cfg_data;
				REG_BAND_TWO:   cfg_q.band_two_top_mm <= cfg_data;
				REG_MAX_RANGE:  cfg_q.max_range_mm <= cfg_data;
				REG_FAST:       cfg_q.fast_period_ms <= cfg_data;
				REG_MID:        cfg_q.mid_period_ms <= cfg_data;
				REG_SLOW:       cfg_q.slow_period_ms <= cfg_data;
				REG_LOCKOUT:    cfg_q.button_lockout_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage one advances when the result register is free or being drained.
	assign adv = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			channel_s1 <= channel;
			distance_s1 <= distance_mm;
			button_s1 <= button_low;
		end
	end

	// Time base, button lockout and enable.
	dbhp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.action     (action_s1),
		.button_low (button_s1),
		.lockout_ms (cfg_q.button_lockout_ms),
		.ctl        (ctl)
	);

	// One unit per motor channel.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
		assign hit[i] = ctl.sample_ok && (int'(channel_s1) == i);
		dbhp_chan u_chan (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.hit         (hit[i]),
			.distance_mm (distance_s1),
			.cfg         (cfg_q),
			.ctl         (ctl),
			.drive_next  (drv_next[i])
		);
	end

	// Drive fields without a channel read zero.
	for (genvar k = 0; k < OUT_DRIVES; k++) begin : g_pad
		if (k < CHANNELS) begin : g_used
			assign drv_pad[k] = drv_next[k];
		end else begin : g_zero
			assign drv_pad[k] = 1'b0;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drv_q <= drv_pad;
			en_q <= ctl.enabled;
		end
	end

	assign out_valid = out_valid_q;
	assign drive_forward = drv_q[0];
	assign drive_left = drv_q[1];
	assign drive_right = drv_q[2];
	assign motors_enabled = en_q;

	// A disabled result never shows a running motor.
	a_disabled_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !en_q |-> !drv_q[0] && !drv_q[1] && !drv_q[2])
		else $error("drive active while motors disabled");

	// A stalled item in stage one is not dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("stage one item lost under stall");

	// A new result only appears after stage one held an item.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a source transaction");

endmodule

### bench/dbhp_checker.sv
// Checker for the distance band haptic pulser: watches the register port and both
// channels, predicts the motor status after every transaction and compares it.
// Depends on dbhp_pkg for the register layout, action codes and widths.
module dbhp_checker import dbhp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        action,
	input  logic [CHAN_W-1:0] channel,
	input  logic [DIST_W-1:0] distance_mm,
	input  logic              button_low,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              drive_forward,
	input  logic              drive_left,
	input  logic              drive_right,
	input  logic              motors_enabled,
	output int                fail_count,
	output int                pending,
	output int                statuses_checked,
	output int                enable_toggles,
	output int                blink_flips
);

	typedef struct packed {
		logic forward;
		logic left;
		logic right;
		logic enabled;
	} motor_status_t;

	// Predicted copy of the registers and of the timing and channel state.
	cfg_t              regs;
	logic [TIME_W-1:0] ms_count;
	logic [TIME_W-1:0] press_time;
	logic              enabled;
	logic [REG_W-1:0]  period    [CHANNELS];
	logic [TIME_W-1:0] last_flip [CHANNELS];
	logic              toggle    [CHANNELS];
	logic              drive     [CHANNELS];

	// Motor status expected for each accepted transaction, oldest first.
	motor_status_t status_queue[$];
	motor_status_t want;
	int errors;
	int checked;
	int toggles;
	int flips;

	// Apply one transaction to the predicted state and return the status after it.
	task automatic advance(input action_t act, input logic [CHAN_W-1:0] ch,
			input logic [DIST_W-1:0] range_mm, input logic pressed,
			output motor_status_t st);
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] lockout;
		case (act)
			ACT_SAMPLE: begin
				// A sample picks off, steady or one of the three blink bands.
				if (enabled && ch < CHANNELS) begin
					if (range_mm == '0 || range_mm > regs.max_range_mm) begin
						period[ch] = '0;
						drive[ch] = 1'b0;
					end else if (range_mm < regs.near_limit_mm) begin
						period[ch] = '0;
						drive[ch] = 1'b1;
					end else if (range_mm <= regs.band_one_top_mm) begin
						period[ch] = regs.fast_period_ms;
					end else if (range_mm <= regs.band_two_top_mm) begin
						period[ch] = regs.mid_period_ms;
					end else begin
						period[ch] = regs.slow_period_ms;
					end
				end
			end
			ACT_TICK: begin
				ms_count = ms_count + 32'd1;
			end
			ACT_BUTTON: begin
				// A press only counts once the lockout has strictly passed.
				elapsed = ms_count - press_time;
				lockout = {16'd0, regs.button_lockout_ms};
				if (pressed && elapsed > lockout) begin
					enabled = ~enabled;
					press_time = ms_count;
					toggles++;
				end
			end
			default: begin
				// Unused code: only the clearing and the flip check below apply.
			end
		endcase

		// Disabled motors lose their blink periods and drives, but not their toggle bits.
		if (!enabled) begin
			for (int i = 0; i < CHANNELS; i++) begin
				period[i] = '0;
				drive[i] = 1'b0;
			end
		end

		// Blinking channels flip once their elapsed time reaches the period.
		for (int i = 0; i < CHANNELS; i++) begin
			elapsed = ms_count - last_flip[i];
			if (period[i] != '0 && elapsed >= {16'd0, period[i]}) begin
				toggle[i] = ~toggle[i];
				drive[i] = toggle[i];
				last_flip[i] = ms_count;
				flips++;
			end
		end

		st.forward = drive[0];
		st.left = drive[1];
		st.right = drive[2];
		st.enabled = enabled;
	endtask

	task automatic check_field(input string name, input logic exp_v, input logic got_v);
		if (got_v !== exp_v) begin
			errors++;
			if (errors <= 10)
				$display("Mismatch on %s in status %0d: expected %b, got %b",
					name, checked, exp_v, got_v);
		end
	endtask

	// Register writes, transaction prediction and result comparison, in edge order.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = CFG_RESET;
			ms_count = '0;
			press_time = '0;
			enabled = 1'b1;
			for (int i = 0; i < CHANNELS; i++) begin
				period[i] = '0;
				last_flip[i] = '0;
				toggle[i] = 1'b0;
				drive[i] = 1'b0;
			end
			status_queue.delete();
			errors = 0;
			checked = 0;
			toggles = 0;
			flips = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NEAR_LIMIT: regs.near_limit_mm = cfg_data;
					REG_BAND_ONE:   regs.band_one_top_mm = cfg_data;
					REG_BAND_TWO:   regs.band_two_top_mm = cfg_data;
					REG_MAX_RANGE:  regs.max_range_mm = cfg_data;
					REG_FAST:       regs.fast_period_ms = cfg_data;
					REG_MID:        regs.mid_period_ms = cfg_data;
					REG_SLOW:       regs.slow_period_ms = cfg_data;
					REG_LOCKOUT:    regs.button_lockout_ms = cfg_data;
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				advance(action_t'(action), channel, distance_mm, button_low, want);
				status_queue.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (status_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected result transaction: %b%b%b enabled %b",
							drive_forward, drive_left, drive_right, motors_enabled);
				end else begin
					want = status_queue.pop_front();
					check_field("drive_forward", want.forward, drive_forward);
					check_field("drive_left", want.left, drive_left);
					check_field("drive_right", want.right, drive_right);
					check_field("motors_enabled", want.enabled, motors_enabled);
					checked++;
				end
			end
		end
		fail_count <= errors;
		pending <= status_queue.size();
		statuses_checked <= checked;
		enable_toggles <= toggles;
		blink_flips <= flips;
	end

endmodule

### bench/distance_band_haptic_pulser_test.sv
// Testbench top for the distance band haptic pulser: clock, reset, register
// settings and transaction stimulus with random idling, plus the final verdict.
// Depends on dbhp_pkg, the block itself and dbhp_checker.
module distance_band_haptic_pulser_test;
	import dbhp_pkg::*;

	localparam int SQUEEZE_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        action = '0;
	logic [CHAN_W-1:0] channel = '0;
	logic [DIST_W-1:0] distance_mm = '0;
	logic              button_low = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              drive_forward;
	logic              drive_left;
	logic              drive_right;
	logic              motors_enabled;

	int fail_count;
	int pending;
	int statuses_checked;
	int enable_toggles;
	int blink_flips;

	// Zero means no idling; otherwise roughly one chance in idle_odds of a burst.
	int   idle_odds = 0;
	bit   squeeze_req = 1'b0;
	int   cycle_count = 0;
	int   items_sent = 0;
	cfg_t cfg_now = CFG_RESET;

	always #2 clk = ~clk;

	distance_band_haptic_pulser u_top (.*);

	dbhp_checker u_checker (.*);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding",
				cycle_count, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : result_sink
		int stall;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				out_ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(0, 3 * idle_odds) == 0) begin
				stall = $urandom_range(1, 12);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one transaction, possibly after an idle burst, and wait for acceptance.
	task automatic send_item(input action_t act, input logic [CHAN_W-1:0] ch,
			input logic [DIST_W-1:0] range_mm, input logic pressed);
		int gap;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		distance_mm <= range_mm;
		button_low <= pressed;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Wait until the block is drained, then write all eight registers.
	task automatic load_registers(input cfg_t value);
		logic [IDX_W-1:0] idx   [8];
		logic [REG_W-1:0] words [8];
		idx = '{REG_NEAR_LIMIT, REG_BAND_ONE, REG_BAND_TWO, REG_MAX_RANGE,
			REG_FAST, REG_MID, REG_SLOW, REG_LOCKOUT};
		words = '{value.near_limit_mm, value.band_one_top_mm, value.band_two_top_mm,
			value.max_range_mm, value.fast_period_ms, value.mid_period_ms,
			value.slow_period_ms, value.button_lockout_ms};
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= words[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_now = value;
	endtask

	// Ordered band edges with short periods, so blinking shows up within a few ticks.
	function automatic cfg_t random_bands(input int max_period);
		cfg_t c;
		c.near_limit_mm = REG_W'($urandom_range(0, 400));
		c.band_one_top_mm = c.near_limit_mm + REG_W'($urandom_range(0, 400));
		c.band_two_top_mm = c.band_one_top_mm + REG_W'($urandom_range(0, 600));
		c.max_range_mm = c.band_two_top_mm + REG_W'($urandom_range(0, 2000));
		c.fast_period_ms = REG_W'($urandom_range(1, max_period));
		c.mid_period_ms = REG_W'($urandom_range(1, max_period));
		c.slow_period_ms = REG_W'($urandom_range(1, max_period));
		c.button_lockout_ms = REG_W'($urandom_range(0, 12));
		return c;
	endfunction

	// Distances aimed at the band edges of the current setting.
	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return DIST_W'($urandom_range(0, cfg_now.near_limit_mm));
			2: return cfg_now.near_limit_mm;
			3: return DIST_W'($urandom_range(cfg_now.near_limit_mm,
				cfg_now.band_one_top_mm));
			4: return cfg_now.band_one_top_mm;
			5: return DIST_W'($urandom_range(cfg_now.band_one_top_mm,
				cfg_now.band_two_top_mm));
			6: return cfg_now.band_two_top_mm;
			7: return DIST_W'($urandom_range(cfg_now.band_two_top_mm,
				cfg_now.max_range_mm));
			8: return DIST_W'($urandom_range(cfg_now.max_range_mm, 16'hFFFF));
			default: return DIST_W'($urandom);
		endcase
	endfunction

	// Random mix: mostly samples and ticks, a few button events and unused codes.
	task automatic run_random(input int count);
		int pick;
		logic [CHAN_W-1:0] ch;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			ch = ($urandom_range(0, 9) == 0) ? 2'd3 : CHAN_W'($urandom_range(0, 2));
			if (pick < 45)
				send_item(ACT_SAMPLE, ch, pick_distance(), 1'($urandom_range(0, 1)));
			else if (pick < 88)
				send_item(ACT_TICK, CHAN_W'($urandom_range(0, 3)), DIST_W'($urandom),
					1'($urandom_range(0, 1)));
			else if (pick < 94)
				send_item(ACT_BUTTON, CHAN_W'($urandom_range(0, 3)), DIST_W'($urandom),
					1'($urandom_range(0, 1)));
			else
				send_item(ACT_NONE, CHAN_W'($urandom_range(0, 3)), DIST_W'($urandom),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin : stimulus
		cfg_t c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset band edges with short periods and lockout.
		c = CFG_RESET;
		c.fast_period_ms = 16'd2;
		c.mid_period_ms = 16'd3;
		c.slow_period_ms = 16'd5;
		c.button_lockout_ms = 16'd3;
		load_registers(c);
		send_item(ACT_SAMPLE, 2'd0, 16'd0, 1'b0);
		send_item(ACT_SAMPLE, 2'd1, 16'd100, 1'b0);
		send_item(ACT_SAMPLE, 2'd2, 16'hFFFF, 1'b0);
		send_item(ACT_SAMPLE, 2'd0, 16'd300, 1'b0);
		send_item(ACT_SAMPLE, 2'd1, 16'd700, 1'b0);
		send_item(ACT_SAMPLE, 2'd2, 16'd2000, 1'b0);
		// Channel beyond the last motor and the unused action code.
		send_item(ACT_SAMPLE, 2'd3, 16'd100, 1'b1);
		send_item(ACT_NONE, 2'd3, 16'hFFFF, 1'b1);
		repeat (6) send_item(ACT_TICK, 2'd0, 16'd0, 1'b0);
		// Released button, then a press that disables the motors.
		send_item(ACT_BUTTON, 2'd0, 16'd0, 1'b0);
		send_item(ACT_BUTTON, 2'd0, 16'd0, 1'b1);
		send_item(ACT_SAMPLE, 2'd0, 16'd100, 1'b0);
		send_item(ACT_TICK, 2'd0, 16'd0, 1'b0);
		// A press inside the lockout is ignored; a later one enables again.
		send_item(ACT_BUTTON, 2'd0, 16'd0, 1'b1);
		repeat (3) send_item(ACT_TICK, 2'd0, 16'd0, 1'b0);
		send_item(ACT_BUTTON, 2'd0, 16'd0, 1'b1);
		send_item(ACT_SAMPLE, 2'd0, 16'd500, 1'b0);
		send_item(ACT_SAMPLE, 2'd1, 16'd1000, 1'b0);
		send_item(ACT_SAMPLE, 2'd2, 16'd199, 1'b0);
		send_item(ACT_SAMPLE, 2'd0, 16'd200, 1'b0);

		c = random_bands(6);
		load_registers(c);
		idle_odds = 4;
		run_random(120);

		// The result side holds off while items keep coming, so the block fills up.
		c = random_bands(4);
		load_registers(c);
		idle_odds = 0;
		squeeze_req = 1'b1;
		run_random(100);

		c = CFG_RESET;
		load_registers(c);
		idle_odds = 6;
		run_random(150);

		// Fast band with a zero period leaves those channels holding their last drive without blinking.
		c = random_bands(5);
		c.fast_period_ms = '0;
		load_registers(c);
		idle_odds = 3;
		run_random(100);

		c = '0;
		load_registers(c);
		idle_odds = 5;
		run_random(60);

		c = '1;
		load_registers(c);
		run_random(60);

		// Unordered band edges, periods that may be zero.
		c = {$urandom, $urandom, $urandom, $urandom};
		c.fast_period_ms = REG_W'($urandom_range(0, 6));
		c.mid_period_ms = REG_W'($urandom_range(0, 6));
		c.slow_period_ms = REG_W'($urandom_range(0, 6));
		c.button_lockout_ms = REG_W'($urandom_range(0, 8));
		load_registers(c);
		idle_odds = 4;
		run_random(120);

		// Closing stretch at full rate on both sides.
		c = random_bands(6);
		load_registers(c);
		idle_odds = 0;
		run_random(150);

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions over nine register settings, %0d results checked.",
			items_sent, statuses_checked);
		$display("Saw %0d enable toggles and %0d blink flips; %0d mismatches.",
			enable_toggles, blink_flips, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
src/dbhp_pkg.sv
src/dbhp_ctrl.sv
src/dbhp_chan.sv
src/distance_band_haptic_pulser.sv
bench/dbhp_checker.sv
bench/distance_band_haptic_pulser_test.sv
